// ----- rtl/lgs_pkg.sv -----
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types, constants and limit compares for the line gradient block.
// ----------------------------------------------------------------------------
package lgs_pkg;

  localparam int LGS_SAMPLE_BITS = 16;
  localparam int LGS_LIMIT_W     = 15;
  localparam logic [LGS_LIMIT_W-1:0] LGS_LIMIT_RESET = 15'd1600;
  // Compare width covers the widest difference (32-bit samples) plus sign.
  localparam int LGS_CMP_W       = 34;
  localparam int LGS_QUEUE_DEPTH = 4;

  // Line fill state of the front end.
  typedef enum logic [1:0] {
    FILL_EMPTY,
    FILL_ONE,
    FILL_TWO,
    FILL_RUN
  } lgs_fill_t;

  // What one result slot of a queued request does.
  typedef enum logic [1:0] {
    SLOT_NONE,
    SLOT_RAW,
    SLOT_CORR,
    SLOT_TAIL
  } lgs_slot_kind_t;

  typedef struct packed {
    lgs_slot_kind_t kind;
    logic           big;       // difference strictly beyond the limit
    logic           edge_hit;  // sample itself beyond the limit
    logic           nd_ok;     // next raw difference strictly inside
  } lgs_slot_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lgs_q_status_t;

  function automatic logic lgs_is_big(logic signed [LGS_CMP_W-1:0] v,
                                      logic [LGS_LIMIT_W-1:0] lim);
    logic signed [LGS_CMP_W-1:0] l;
    l = signed'({{(LGS_CMP_W-LGS_LIMIT_W){1'b0}}, lim});
    return (v > l) || (v < -l);
  endfunction

  function automatic logic lgs_is_small(logic signed [LGS_CMP_W-1:0] v,
                                        logic [LGS_LIMIT_W-1:0] lim);
    logic signed [LGS_CMP_W-1:0] l;
    l = signed'({{(LGS_CMP_W-LGS_LIMIT_W){1'b0}}, lim});
    return (v < l) && (v > -l);
  endfunction

endpackage

// ----- rtl/lgs_if.sv -----
// ----------------------------------------------------------------------------
// lgs_if
// Valid/ready channel interfaces for samples in and gradients out.
// ----------------------------------------------------------------------------
interface lgs_in_if import lgs_pkg::*; #(
  parameter int SAMPLE_BITS = LGS_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          line_end;

  modport source (output valid, output sample, output line_end, input ready);
  modport sink   (input valid, input sample, input line_end, output ready);
endinterface

interface lgs_out_if import lgs_pkg::*; #(
  parameter int SAMPLE_BITS = LGS_SAMPLE_BITS
);
  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_BITS:0] gradient;
  logic                        last_of_line;

  modport source (output valid, output gradient, output last_of_line, input ready);
  modport sink   (input valid, input gradient, input last_of_line, output ready);
endinterface

// ----- rtl/lgs_front.sv -----
// ----------------------------------------------------------------------------
// lgs_front
// Accept samples, track line fill, form differences and classify results.
// ----------------------------------------------------------------------------
module lgs_front import lgs_pkg::*; #(
  parameter int SAMPLE_BITS = LGS_SAMPLE_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  lgs_in_if.sink                      in_chan,
  input  logic [LGS_LIMIT_W-1:0]      edge_limit,
  input  lgs_q_status_t               q_status,
  output logic                        push,
  output lgs_slot_ctrl_t              ctrl0,
  output lgs_slot_ctrl_t              ctrl1,
  output logic signed [SAMPLE_BITS:0] diff0,
  output logic signed [SAMPLE_BITS:0] nd0,
  output logic signed [SAMPLE_BITS:0] diff1
);

  localparam int DW = SAMPLE_BITS + 1;

  lgs_fill_t                     fill_r, fill_nxt;
  logic                          tail_r, tail_nxt;
  logic signed [SAMPLE_BITS-1:0] older_r, older_nxt;
  logic signed [SAMPLE_BITS-1:0] newer_r, newer_nxt;
  logic                          accept;
  logic signed [DW-1:0]          d_on, d_ns, d_os;
  logic                          older_big, newer_big, d_on_big, d_ns_big;
  logic                          d_ns_ok, zero_ok;

  function automatic logic signed [LGS_CMP_W-1:0] to_cmp(logic signed [DW-1:0] v);
    return {{(LGS_CMP_W-DW){v[DW-1]}}, v};
  endfunction

  assign in_chan.ready = !q_status.full;
  assign accept        = in_chan.valid && in_chan.ready;

  assign d_on = {older_r[SAMPLE_BITS-1], older_r} - {newer_r[SAMPLE_BITS-1], newer_r};
  assign d_ns = {newer_r[SAMPLE_BITS-1], newer_r}
              - {in_chan.sample[SAMPLE_BITS-1], in_chan.sample};
  assign d_os = {older_r[SAMPLE_BITS-1], older_r}
              - {in_chan.sample[SAMPLE_BITS-1], in_chan.sample};

  assign older_big = lgs_is_big(to_cmp({older_r[SAMPLE_BITS-1], older_r}), edge_limit);
  assign newer_big = lgs_is_big(to_cmp({newer_r[SAMPLE_BITS-1], newer_r}), edge_limit);
  assign d_on_big  = lgs_is_big(to_cmp(d_on), edge_limit);
  assign d_ns_big  = lgs_is_big(to_cmp(d_ns), edge_limit);
  assign d_ns_ok   = lgs_is_small(to_cmp(d_ns), edge_limit);
  assign zero_ok   = lgs_is_small('0, edge_limit);

  // Next fill state
  always_comb begin
    unique case (fill_r)
      FILL_EMPTY: fill_nxt = in_chan.line_end ? FILL_EMPTY : FILL_ONE;
      FILL_ONE:   fill_nxt = in_chan.line_end ? FILL_EMPTY : FILL_TWO;
      FILL_TWO:   fill_nxt = in_chan.line_end ? FILL_EMPTY : FILL_RUN;
      FILL_RUN:   fill_nxt = in_chan.line_end ? FILL_EMPTY : FILL_RUN;
      default:    fill_nxt = FILL_EMPTY;
    endcase
  end

  // Result slots and sample shift
  always_comb begin
    ctrl0     = '0;
    ctrl1     = '0;
    diff0     = '0;
    nd0       = '0;
    diff1     = '0;
    older_nxt = older_r;
    newer_nxt = newer_r;
    tail_nxt  = 1'b0;
    unique case (fill_r)
      FILL_EMPTY: begin
        older_nxt = in_chan.sample;
        if (tail_r) begin
          ctrl0.kind = SLOT_TAIL;
          if (in_chan.line_end) ctrl1.kind = SLOT_TAIL;
        end else if (in_chan.line_end) begin
          ctrl0.kind = SLOT_TAIL;
        end
      end
      FILL_ONE: begin
        newer_nxt = in_chan.sample;
        if (in_chan.line_end) begin
          ctrl0.kind = SLOT_RAW;
          diff0      = d_os;
          ctrl1.kind = SLOT_TAIL;
        end
      end
      FILL_TWO, FILL_RUN: begin
        diff0 = d_on;
        if (fill_r == FILL_TWO) begin
          ctrl0.kind = SLOT_RAW;
        end else begin
          ctrl0.kind     = SLOT_CORR;
          ctrl0.big      = d_on_big;
          ctrl0.edge_hit = older_big;
          ctrl0.nd_ok    = d_ns_ok;
          nd0            = d_ns;
        end
        if (in_chan.line_end) begin
          ctrl1.kind     = SLOT_CORR;
          ctrl1.big      = d_ns_big;
          ctrl1.edge_hit = newer_big;
          ctrl1.nd_ok    = zero_ok;
          diff1          = d_ns;
          tail_nxt       = 1'b1;
        end else begin
          older_nxt = newer_r;
          newer_nxt = in_chan.sample;
        end
      end
      default: begin
        ctrl0.kind = SLOT_NONE;
      end
    endcase
  end

  assign push = accept && (ctrl0.kind != SLOT_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= FILL_EMPTY;
      tail_r <= 1'b0;
    end else if (accept) begin
      fill_r <= fill_nxt;
      tail_r <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      older_r <= older_nxt;
      newer_r <= newer_nxt;
    end
  end

endmodule

// ----- rtl/lgs_queue.sv -----
// ----------------------------------------------------------------------------
// lgs_queue
// Short FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
module lgs_queue import lgs_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = LGS_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [W-1:0]  wdata,
  input  logic          pop,
  output logic [W-1:0]  rdata,
  output lgs_q_status_t status
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign rdata        = mem_r[rd_ptr_r];
  assign status.full  = (count_r == CW'(DEPTH));
  assign status.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

// ----- rtl/lgs_back.sv -----
// ----------------------------------------------------------------------------
// lgs_back
// Apply edge correction against the prior output and drive results.
// ----------------------------------------------------------------------------
module lgs_back import lgs_pkg::*; #(
  parameter int SAMPLE_BITS = LGS_SAMPLE_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  lgs_slot_ctrl_t              ctrl0,
  input  lgs_slot_ctrl_t              ctrl1,
  input  logic signed [SAMPLE_BITS:0] diff0,
  input  logic signed [SAMPLE_BITS:0] nd0,
  input  logic signed [SAMPLE_BITS:0] diff1,
  input  logic [LGS_LIMIT_W-1:0]      edge_limit,
  output logic                        pop,
  lgs_out_if.source                   out_chan
);

  localparam int DW = SAMPLE_BITS + 1;

  logic                 slot_r;
  logic                 out_valid_r, last_r;
  logic signed [DW-1:0] prior_r, grad_r, grad_nxt;
  lgs_slot_ctrl_t       cur;
  logic signed [DW-1:0] cur_diff, cur_nd, fixed;
  logic                 prior_ok, advance, second;

  function automatic logic signed [LGS_CMP_W-1:0] to_cmp(logic signed [DW-1:0] v);
    return {{(LGS_CMP_W-DW){v[DW-1]}}, v};
  endfunction

  assign cur      = slot_r ? ctrl1 : ctrl0;
  assign cur_diff = slot_r ? diff1 : diff0;
  assign cur_nd   = slot_r ? '0 : nd0;
  assign prior_ok = lgs_is_small(to_cmp(prior_r), edge_limit);

  // Replace a big difference by a small neighbor, or by zero if neither is small; order set by the sample.
  always_comb begin
    priority if (!cur.big)                  fixed = cur_diff;
    else if (cur.edge_hit && cur.nd_ok)     fixed = cur_nd;
    else if (prior_ok)                      fixed = prior_r;
    else if (!cur.edge_hit && cur.nd_ok)    fixed = cur_nd;
    else                                    fixed = '0;
  end

  always_comb begin
    unique case (cur.kind)
      SLOT_RAW:  grad_nxt = cur_diff;
      SLOT_CORR: grad_nxt = fixed;
      default:   grad_nxt = '0;
    endcase
  end

  assign advance = q_valid && (!out_valid_r || out_chan.ready);
  assign second  = !slot_r && (ctrl1.kind != SLOT_NONE);
  assign pop     = advance && !second;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      slot_r      <= 1'b0;
      prior_r     <= '0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
      slot_r      <= second;
      if (cur.kind != SLOT_TAIL) prior_r <= grad_nxt;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      grad_r <= grad_nxt;
      last_r <= (cur.kind == SLOT_TAIL);
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.gradient     = grad_r;
  assign out_chan.last_of_line = last_r;

endmodule

// ----- rtl/line_gradient_edge_suppress.sv -----
// ----------------------------------------------------------------------------
// line_gradient_edge_suppress
// Forward difference along one image line with edge suppression.
// ----------------------------------------------------------------------------
//
//  port       | dir | payload                              | handshake
//  -----------+-----+--------------------------------------+------------
//  in_chan    | in  | sample (SAMPLE_BITS, s), line_end    | valid/ready
//  out_chan   | out | gradient (SAMPLE_BITS+1, s), last    | valid/ready
//  cfg_*      | in  | cfg_wdata = edge_limit (15, u)       | cfg_we
//
//  A request is taken every cycle while the request queue has room; the
//  front end turns it into zero to two results in the same cycle.
//  A taken request is written into the request queue and loads the output
//  register from there once that register is free.
//  While the receiver is ready, the back end drives one result per cycle
//  through its output register; a request with two results leaves the queue
//  only with its second result, and a line of L samples yields L results.
//  Reset (rst_n low, synchronous) empties the queue, restarts the line and
//  loads the limit with 100.0 (1600 in Q11.4).
//  Either side may stall on its own; the queue absorbs the difference.
//  The closing zero of a line of three or more samples is released by the
//  first request of the following line.
//
module line_gradient_edge_suppress import lgs_pkg::*; #(
  parameter int SAMPLE_BITS = LGS_SAMPLE_BITS,
  parameter int QUEUE_DEPTH = LGS_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  lgs_in_if.sink                 in_chan,
  lgs_out_if.source              out_chan,
  input  logic                   cfg_we,
  input  logic [LGS_LIMIT_W-1:0] cfg_wdata
);

  localparam int DW     = SAMPLE_BITS + 1;
  localparam int CTRL_W = $bits(lgs_slot_ctrl_t);
  localparam int EW     = 2 * CTRL_W + 3 * DW;

  logic [LGS_LIMIT_W-1:0] limit_r;

  // front -> queue
  logic                 q_push;
  lgs_slot_ctrl_t       f_ctrl0, f_ctrl1;
  logic signed [DW-1:0] f_diff0, f_nd0, f_diff1;
  logic [EW-1:0]        q_wdata, q_rdata;

  // queue -> back
  logic                 q_pop;
  lgs_q_status_t        q_status;
  lgs_slot_ctrl_t       h_ctrl0, h_ctrl1;
  logic signed [DW-1:0] h_diff0, h_nd0, h_diff1;

  // Hold the limit; load on every write strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LGS_LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  lgs_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .edge_limit (limit_r),
    .q_status   (q_status),
    .push       (q_push),
    .ctrl0      (f_ctrl0),
    .ctrl1      (f_ctrl1),
    .diff0      (f_diff0),
    .nd0        (f_nd0),
    .diff1      (f_diff1)
  );

  // Pack a classified request into one queue entry.
  assign q_wdata = {f_ctrl0, f_ctrl1, f_diff0, f_nd0, f_diff1};

  lgs_queue #(
    .W     (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_status)
  );

  assign {h_ctrl0, h_ctrl1, h_diff0, h_nd0, h_diff1} = q_rdata;

  lgs_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (!q_status.empty),
    .ctrl0      (h_ctrl0),
    .ctrl1      (h_ctrl1),
    .diff0      (h_diff0),
    .nd0        (h_nd0),
    .diff1      (h_diff1),
    .edge_limit (limit_r),
    .pop        (q_pop),
    .out_chan   (out_chan)
  );

  // The closing result of a line always carries a zero gradient.
  a_last_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.last_of_line |-> out_chan.gradient == '0)
    else $error("closing result with nonzero gradient");

  // Never write a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_status.full)
    else $error("request queue overflow");

  // Never retire from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_status.empty)
    else $error("request queue underflow");

endmodule

// ----- bench/tb_gradient_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gradient_pkg
// Expected-gradient tracker for the line gradient bench: mirrors the line
// fill, the edge suppression and the owed closing zero, and checks results.
// ----------------------------------------------------------------------------
package tb_gradient_pkg;
  import lgs_pkg::*;

  class gradient_tracker;
    typedef struct {
      int grad;
      bit last;
    } grad_due_t;

    int        edge_limit;
    lgs_fill_t fill;
    int        older;
    int        newer;
    int        prior;
    bit        tail_owed;
    grad_due_t due_q[$];
    int        errors;
    int        n_checked;

    function new();
      edge_limit = LGS_LIMIT_RESET;
      fill       = FILL_EMPTY;
      older      = 0;
      newer      = 0;
      prior      = 0;
      tail_owed  = 1'b0;
      errors     = 0;
      n_checked  = 0;
    endfunction

    function void set_limit(int v);
      edge_limit = v;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function bit over_limit(int v);
      return (v < -edge_limit) || (v > edge_limit);
    endfunction

    function bit under_limit(int v);
      return (v > -edge_limit) && (v < edge_limit);
    endfunction

    // Replace a big difference by a neighbour strictly inside the limit, or by zero if none is.
    function int suppress(int d, int here, int next_d, int prev_g);
      if (!over_limit(d)) return d;
      if (over_limit(here)) begin
        if (under_limit(next_d)) return next_d;
        if (under_limit(prev_g)) return prev_g;
        return 0;
      end
      if (under_limit(prev_g)) return prev_g;
      if (under_limit(next_d)) return next_d;
      return 0;
    endfunction

    function void push(int g, bit last);
      grad_due_t w;
      w.grad = g;
      w.last = last;
      due_q.push_back(w);
    endfunction

    function void close_or_shift(int s, bit line_end);
      int g;
      if (line_end) begin
        g = suppress(newer - s, newer, 0, prior);
        push(g, 1'b0);
        prior     = g;
        tail_owed = 1'b1;
        fill      = FILL_EMPTY;
      end else begin
        older = newer;
        newer = s;
        fill  = FILL_RUN;
      end
    endfunction

    function void note_request(int s, bit line_end);
      int g;
      if (tail_owed) begin
        push(0, 1'b1);
        tail_owed = 1'b0;
      end
      case (fill)
        FILL_EMPTY: begin
          older = s;
          if (line_end) push(0, 1'b1);
          else fill = FILL_ONE;
        end
        FILL_ONE: begin
          newer = s;
          if (line_end) begin
            push(older - newer, 1'b0);
            push(0, 1'b1);
            fill = FILL_EMPTY;
          end else begin
            fill = FILL_TWO;
          end
        end
        FILL_TWO: begin
          prior = older - newer;
          push(prior, 1'b0);
          close_or_shift(s, line_end);
        end
        default: begin
          g = suppress(older - newer, older, newer - s, prior);
          push(g, 1'b0);
          prior = g;
          close_or_shift(s, line_end);
        end
      endcase
    endfunction

    function void check_gradient(logic signed [LGS_SAMPLE_BITS:0] g, logic last);
      grad_due_t                   w;
      logic signed [LGS_SAMPLE_BITS:0] want_g;
      n_checked++;
      if (due_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected gradient, expected none, actual %0d last %0b",
                 $time, g, last);
        return;
      end
      w      = due_q.pop_front();
      want_g = w.grad;
      if (g !== want_g) begin
        errors++;
        $display("%0t: gradient mismatch, expected %0d, actual %0d", $time, want_g, g);
      end
      if (last !== w.last) begin
        errors++;
        $display("%0t: last_of_line mismatch, expected %0b, actual %0b",
                 $time, w.last, last);
      end
    endfunction
  endclass

endpackage

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the line gradient block: random image lines under several edge
// limits, bursty sender, stalling receiver, every gradient checked in order.
// ----------------------------------------------------------------------------
module tb_top;
  import lgs_pkg::*;
  import tb_gradient_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int PHASE_ITEMS    = 220;
  localparam int NUM_PHASES     = 8;
  localparam int LIMIT_MAX      = (1 << LGS_LIMIT_W) - 1;
  localparam int SAMPLE_MAX     = (1 << (LGS_SAMPLE_BITS - 1)) - 1;
  localparam int SAMPLE_MIN     = -(1 << (LGS_SAMPLE_BITS - 1));
  localparam int SETTLE_CYCLES  = 8;
  localparam int DIRECTED_ITEMS = 22;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [LGS_LIMIT_W-1:0] cfg_wdata;

  lgs_in_if  in_if ();
  lgs_out_if out_if ();

  line_gradient_edge_suppress DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  gradient_tracker board = new();

  // Sender and receiver bookkeeping.
  int n_sent      = 0;
  int n_limits    = 0;
  int cur_limit   = LGS_LIMIT_RESET;
  int last_sample = 0;
  int burst_left  = 0;
  int quiet_left  = 0;   // requests that must go back to back
  int hold_asked  = 0;   // bumped by the sender to ask for a long receiver hold
  int hold_taken  = 0;
  int cycle_count = 0;

  // Free-running clock, 10 ns period.
  always #5 clk = ~clk;

  // Watchdog: a correct run ends far below this.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: check every accepted gradient, then pick ready for the next
  // cycle. Stall modes change now and then; a long hold is taken when asked.
  // --------------------------------------------------------------------------
  initial begin
    int rx_mode;
    int rx_mode_left;
    int rx_hold_left;
    int rx_tick;
    rx_mode      = 0;
    rx_mode_left = 0;
    rx_hold_left = 0;
    rx_tick      = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      rx_tick++;
      // Values read here are the ones the block saw at this edge.
      if (rst_n && out_if.valid && out_if.ready)
        board.check_gradient(out_if.gradient, out_if.last_of_line);
      if (hold_asked != hold_taken) begin
        hold_taken   = hold_asked;
        rx_hold_left = 120;
      end
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(20, 300);
      end else begin
        rx_mode_left--;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= ($urandom_range(0, 1) == 1);
          2: out_if.ready <= ($urandom_range(0, 7) != 0);
          default: out_if.ready <= ((rx_tick % 9) >= 4);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------

  // Offer one request and hold it until the block takes it.
  task automatic send_request(input int s, input bit line_end);
    in_if.valid    <= 1'b1;
    in_if.sample   <= s[LGS_SAMPLE_BITS-1:0];
    in_if.line_end <= line_end;
    do @(posedge clk); while (!in_if.ready);
    board.note_request(s, line_end);
    n_sent++;
  endtask

  // Drop valid and idle; n (n >= 1) sets the length of the idle stretch.
  task automatic idle_sender(input int n);
    in_if.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Drop valid and wait until every expected gradient has come back.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // Send one request, then end the burst with a random gap when it runs out.
  task automatic offer(input int s, input bit line_end);
    int gap;
    send_request(s, line_end);
    if (quiet_left > 0) begin
      quiet_left--;
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) idle_sender(gap);
    end
  endtask

  // Write the edge limit while the block is idle. Every phase ends on a
  // one-sample line, so no closing zero is owed at this point.
  task automatic write_limit(input int v);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v[LGS_LIMIT_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_limit(v);
    cur_limit = v;
    n_limits++;
  endtask

  // Next sample: mostly a walk whose steps straddle the limit, plus random values
  // around zero, wide random values and the two extremes.
  function automatic int next_sample(int lim);
    int                              r;
    int                              span;
    int                              v;
    logic signed [LGS_SAMPLE_BITS-1:0] raw;
    r    = $urandom_range(0, 15);
    span = lim + lim / 2 + 3;
    case (r)
      0, 1: begin
        raw = LGS_SAMPLE_BITS'($urandom);
        v   = raw;
      end
      2: v = ($urandom_range(0, 1) == 1) ? SAMPLE_MAX : SAMPLE_MIN;
      3, 4: v = int'($urandom_range(0, 2 * span)) - span;
      default: v = last_sample + int'($urandom_range(0, 2 * span)) - span;
    endcase
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    if (v < SAMPLE_MIN) v = SAMPLE_MIN;
    last_sample = v;
    return v;
  endfunction

  // Line length: mostly short lines, a few one- and two-sample lines, rarely long.
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 1;
    if (r == 1) return 2;
    if (r == 2) return $urandom_range(20, 40);
    return $urandom_range(3, 10);
  endfunction

  // Random lines under the current limit; with pressure set, ask for a long
  // receiver hold while requests keep coming, and pause mid-line until drained.
  task automatic run_phase(input int n_items, input bit pressure);
    int target;
    int len;
    int lines;
    bit held;
    bit paused;
    target = n_sent + n_items;
    lines  = 0;
    held   = 1'b0;
    paused = 1'b0;
    while (n_sent < target) begin
      len = pick_len();
      if (pressure && !held && lines == 4) begin
        hold_asked++;
        quiet_left = 50;
        held       = 1'b1;
      end
      for (int k = 0; k < len; k++) begin
        offer(next_sample(cur_limit), k == len - 1);
        if (pressure && held && !paused && quiet_left == 0 && k == 1 && len > 3) begin
          wait_drained();
          paused = 1'b1;
        end
      end
      lines++;
    end
    // Close with a one-sample line to release any owed closing zero.
    offer(next_sample(cur_limit), 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int dir_samples [DIRECTED_ITEMS];
    bit dir_ends    [DIRECTED_ITEMS];
    int limit_plan  [NUM_PHASES];

    // Directed lines, all under the reset limit of 100.0:
    //   one sample; two samples at both extremes (largest raw differences);
    //   three samples with a big step whose sample is beyond the limit;
    //   five samples hitting both neighbour preferences; four samples where
    //   no neighbour is inside; a difference exactly at the limit; and a
    //   closing single sample to release the owed zero.
    dir_samples = '{32767,
                    -32768, 32767,
                    32767, -32768,
                    0, 2000, 0,
                    0, 100, 3000, 200, 150,
                    0, 5000, -5000, 5000,
                    0, 1600, 0, 0,
                    -7};
    dir_ends    = '{1,
                    0, 1,
                    0, 1,
                    0, 0, 1,
                    0, 0, 0, 0, 1,
                    0, 0, 0, 1,
                    0, 0, 0, 1,
                    1};

    limit_plan = '{LGS_LIMIT_RESET, 0, LIMIT_MAX, 1, 24,
                   $urandom_range(0, LIMIT_MAX), $urandom_range(100, 3000),
                   LGS_LIMIT_RESET};

    in_if.valid    = 1'b0;
    in_if.sample   = '0;
    in_if.line_end = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    rst_n          = 1'b0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    for (int i = 0; i < DIRECTED_ITEMS; i++)
      offer(dir_samples[i], dir_ends[i]);

    // The first phase runs on the reset limit; later phases rewrite it.
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) write_limit(limit_plan[p]);
      run_phase(PHASE_ITEMS, p == 0);
    end

    // Drain, then give the block time to show any stray result.
    wait_drained();
    repeat (20) @(posedge clk);

    $display("tb_top: %0d requests sent, %0d gradients checked, %0d limit writes",
             n_sent, board.n_checked, n_limits);
    $display("tb_top: limits covered 0, 1, 24, 100.0, max and two random values");
    if (board.errors == 0 && board.pending() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/lgs_pkg.sv
rtl/lgs_if.sv
rtl/lgs_front.sv
rtl/lgs_queue.sv
rtl/lgs_back.sv
rtl/line_gradient_edge_suppress.sv
bench/tb_gradient_pkg.sv
bench/tb_top.sv
